// ----- sv/sacl_pkg.sv -----
`default_nettype none

package sacl_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS_USED  = 2'd2;

  // Access kinds
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;

  // One cache line as kept in a set row
  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [31:0] stamp;
  } line_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
    logic clr_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_blocked;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/sacl_ram.sv -----
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/sacl_ctrl.sv -----
`default_nettype none

module sacl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sacl_pkg::sts_t sts,
  output sacl_pkg::cmd_t     cmd
);

  sacl_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      sacl_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sacl_pkg::ST_LOOK;
        end
      end
      sacl_pkg::ST_LOOK: begin
        // hold until the result register can take the beat
        if (!sts.out_blocked) begin
          cmd.commit = 1'b1;
          state_nxt  = sacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sacl_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/sacl_dp.sv -----
`default_nettype none

module sacl_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sacl_pkg::cmd_t cmd,
  output sacl_pkg::sts_t      sts,
  input  wire logic [1:0]     in_req_type,
  input  wire logic [63:0]    in_address,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [4:0]     cfg_wdata,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_was_hit,
  output logic                out_was_miss,
  output logic                out_was_evict,
  output logic                out_store_hit,
  output logic [31:0]         out_hit_total,
  output logic [31:0]         out_miss_total,
  output logic [31:0]         out_evict_total
);

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LW    = $bits(sacl_pkg::line_t);
  localparam int ROW_W = MAX_WAYS * LW;

  // Configuration registers
  logic [2:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd0;
      block_bits_r <= 5'd0;
      ways_used_r  <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacl_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_wdata[2:0];
        sacl_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        sacl_pkg::CFG_WAYS_USED:  ways_used_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Saturate the set width and associativity
  logic [4:0] sb_eff;
  logic [4:0] ways_eff;

  always_comb begin
    sb_eff = ({2'b00, set_bits_r} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                      : {2'b00, set_bits_r};
    if (ways_used_r == 4'd0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, ways_used_r} > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_used_r};
    end
  end

  // Split the incoming address into set and tag
  logic [63:0]   line_addr;
  logic [63:0]   set_mask;
  logic [63:0]   set_full;
  logic [63:0]   tag_in;
  logic [SW-1:0] set_in;

  always_comb begin
    line_addr = in_address >> block_bits_r;
    set_mask  = (64'd1 << sb_eff) - 64'd1;
    set_full  = line_addr & set_mask;
    set_in    = set_full[SW-1:0];
    tag_in    = line_addr >> sb_eff;
  end

  // Capture the access
  logic [SW-1:0] set_r;
  logic [63:0]   tag_r;
  logic          modify_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r    <= set_in;
      tag_r    <= tag_in;
      modify_r <= (in_req_type == sacl_pkg::REQ_MODIFY);
    end
  end

  // Clearing sweep counter
  logic [SW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + SW'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == SW'(SETS - 1));

  // Set memory, one row holds every way of a set
  logic                  ram_we;
  logic [SW-1:0]         ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [SW-1:0]         ram_raddr;
  logic [ROW_W-1:0]      ram_rdata;
  sacl_pkg::line_t [MAX_WAYS-1:0] row_rd;
  sacl_pkg::line_t [MAX_WAYS-1:0] row_wr;

  assign ram_we    = cmd.clr_step | cmd.commit;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : set_r;
  assign ram_wdata = cmd.clr_step ? '0 : row_wr;
  assign ram_raddr = cmd.capture ? set_in : set_r;
  assign row_rd    = ram_rdata;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Lookup: first hit, first free way, oldest way
  logic [31:0]   clock_r;
  logic [31:0]   clock_nxt;
  logic          hit;
  logic [WW-1:0] hit_way;
  logic          inv_found;
  logic [WW-1:0] inv_way;
  logic [WW-1:0] best_way;
  logic [31:0]   best_stamp;
  logic [WW-1:0] victim;
  logic          evict;

  assign clock_nxt = clock_r + 32'd1;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    inv_found  = 1'b0;
    inv_way    = '0;
    best_way   = '0;
    best_stamp = row_rd[0].stamp;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (5'(w) < ways_eff) begin
        if (!hit && row_rd[w].valid && (row_rd[w].tag == tag_r)) begin
          hit     = 1'b1;
          hit_way = WW'(w);
        end
        if (!inv_found && !row_rd[w].valid) begin
          inv_found = 1'b1;
          inv_way   = WW'(w);
        end
        if ((w > 0) && (row_rd[w].stamp < best_stamp)) begin
          best_way   = WW'(w);
          best_stamp = row_rd[w].stamp;
        end
      end
    end
    victim = inv_found ? inv_way : best_way;
    evict  = !hit && !inv_found;
  end

  // Build the updated row
  always_comb begin
    row_wr = row_rd;
    if (hit) begin
      row_wr[hit_way].stamp = clock_nxt;
    end else begin
      row_wr[victim].valid = 1'b1;
      row_wr[victim].tag   = tag_r;
      row_wr[victim].stamp = clock_nxt;
    end
  end

  // Running totals
  logic [31:0] hits_r, misses_r, evicts_r;
  logic [31:0] hits_nxt, misses_nxt, evicts_nxt;

  assign hits_nxt   = hits_r + 32'(hit) + 32'(modify_r);
  assign misses_nxt = misses_r + 32'(!hit);
  assign evicts_nxt = evicts_r + 32'(evict);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r  <= 32'd0;
      hits_r   <= 32'd0;
      misses_r <= 32'd0;
      evicts_r <= 32'd0;
    end else if (cmd.commit) begin
      clock_r  <= clock_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  // Result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_was_hit     <= hit;
      out_was_miss    <= !hit;
      out_was_evict   <= evict;
      out_store_hit   <= modify_r;
      out_hit_total   <= hits_nxt;
      out_miss_total  <= misses_nxt;
      out_evict_total <= evicts_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign sts.out_blocked = out_valid_r & out_stall;

endmodule

`default_nettype wire

// ----- sv/set_assoc_cache_lru_sim.sv -----
`default_nettype none

// Channel   Ports                                  Beat
// input     in_valid, in_stall, in_req_type,       one trace access
//           in_address
// result    out_valid, out_stall, out_was_hit ..   one lookup outcome and totals
//           out_evict_total
// config    cfg_we, cfg_index, cfg_wdata           one register write
//
// An access first reads the set row from memory, then compares the ways and
// writes the updated row back.
// After reset a clearing pass writes every set row with in_stall high;
// configuration writes are taken during it.
// A new access is taken while a result waits; a stalled result holds the
// next access in its compare cycle until the result register frees.

module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_was_hit,
  output logic             out_was_miss,
  output logic             out_was_evict,
  output logic             out_store_hit,
  output logic [31:0]      out_hit_total,
  output logic [31:0]      out_miss_total,
  output logic [31:0]      out_evict_total,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_wdata
);

  sacl_pkg::cmd_t cmd;
  sacl_pkg::sts_t sts;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_address      (in_address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_was_hit     (out_was_hit),
    .out_was_miss    (out_was_miss),
    .out_was_evict   (out_was_evict),
    .out_store_hit   (out_store_hit),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total),
    .out_evict_total (out_evict_total)
  );

endmodule

`default_nettype wire
